/* src/tsfc_pkg.sv */
// Shared types, constants and helper functions of the touch sample filter.
// Used by every module of the block; depends on nothing.
package tsfc_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int N_SAMPLES   = 5;
	localparam int N_PAIRS     = 10;
	localparam int RANGE_W     = 6;
	localparam int PEN_W       = 4;
	localparam int CAL_W       = 32;
	localparam int CAL_SHIFT   = 19;
	localparam int PIX_W       = 8;
	localparam int ERR_W       = 2;
	localparam int CFG_IDX_W   = 3;

	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 192;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [RANGE_W-1:0] RANGE_CEILING = 6'd35;
	localparam logic [RANGE_W-1:0] RANGE_RESET   = 6'd20;
	localparam logic [CAL_W-1:0]   SCALE_RESET   = 32'd32768;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd4;

	// Both axes flagged: pen absent or bouncing.
	localparam logic [ERR_W-1:0] ERR_ALL = 2'b11;

	typedef logic [N_SAMPLES-1:0][SAMPLE_W-1:0] samples_t;
	typedef logic [N_PAIRS-1:0][SAMPLE_W-1:0]   diffs_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x_sample_0;
		logic [SAMPLE_W-1:0] x_sample_1;
		logic [SAMPLE_W-1:0] x_sample_2;
		logic [SAMPLE_W-1:0] x_sample_3;
		logic [SAMPLE_W-1:0] x_sample_4;
		logic [SAMPLE_W-1:0] y_sample_0;
		logic [SAMPLE_W-1:0] y_sample_1;
		logic [SAMPLE_W-1:0] y_sample_2;
		logic [SAMPLE_W-1:0] y_sample_3;
		logic [SAMPLE_W-1:0] y_sample_4;
		logic [PEN_W-1:0]    pen_levels;
	} in_beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] filtered_x;
		logic [SAMPLE_W-1:0] filtered_y;
		logic [PIX_W-1:0]    screen_x;
		logic [PIX_W-1:0]    screen_y;
		logic [ERR_W-1:0]    error_location;
		logic [SAMPLE_W-1:0] max_deviation;
		logic                sampled;
	} out_beat_t;

	// One classified frame handed from the front end to the back end.
	// Samples are stored in filter order: index 0 is the last conversion.
	typedef struct packed {
		samples_t            xv;
		samples_t            yv;
		diffs_t              xd;
		diffs_t              yd;
		logic [PEN_W-1:0]    pen;
		logic [SAMPLE_W-1:0] dmax;
	} fe_entry_t;

	// Calibration registers are kept as raw two's complement bit patterns.
	typedef struct packed {
		logic [CAL_W-1:0]   x_scale;
		logic [CAL_W-1:0]   x_offset;
		logic [CAL_W-1:0]   y_scale;
		logic [CAL_W-1:0]   y_offset;
		logic [RANGE_W-1:0] min_range;
	} cfg_t;

	// Slot of sample pair (i, j), i < j, in a diffs_t.
	function automatic int pair_idx(input int i, input int j);
		int base;
		if (i == 0) begin
			base = 0;
		end else if (i == 1) begin
			base = 4;
		end else if (i == 2) begin
			base = 7;
		end else begin
			base = 9;
		end
		return base + j - i - 1;
	endfunction

endpackage

/* src/tsfc_chan_if.sv */
// Valid/ready channel carrying one payload beat per handshake.
// The payload type comes from tsfc_pkg at the point of instantiation.
interface tsfc_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/tsfc_front.sv */
// Front end: takes frames, reorders samples and computes all pairwise spreads.
// Depends on tsfc_pkg; feeds tsfc_queue.
module tsfc_front
	import tsfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	input  logic      q_full,
	output logic      push,
	output fe_entry_t push_data
);

	function automatic logic [SAMPLE_W-1:0] absd(input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [SAMPLE_W-1:0] maxd(input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// Balanced max over the ten spreads of one axis.
	function automatic logic [SAMPLE_W-1:0] max_tree(input diffs_t d);
		logic [SAMPLE_W-1:0] l1 [5];
		logic [SAMPLE_W-1:0] l2a, l2b;
		for (int n = 0; n < 5; n++) begin
			l1[n] = maxd(d[2*n], d[2*n+1]);
		end
		l2a = maxd(l1[0], l1[1]);
		l2b = maxd(l1[2], l1[3]);
		return maxd(maxd(l2a, l2b), l1[4]);
	endfunction

	logic     en;
	logic     valid_s1, valid_s2;
	samples_t xv_in, yv_in;
	diffs_t   xd_in, yd_in;
	samples_t xv_s1, yv_s1, xv_s2, yv_s2;
	diffs_t   xd_s1, yd_s1, xd_s2, yd_s2;
	logic [PEN_W-1:0]    pen_s1, pen_s2;
	logic [SAMPLE_W-1:0] dmax_s2;

	assign en       = !valid_s2 || !q_full;
	assign in_ready = en;
	assign push     = valid_s2 && !q_full;

	always_comb begin
		xv_in[0] = in_data.x_sample_4;
		xv_in[1] = in_data.x_sample_3;
		xv_in[2] = in_data.x_sample_2;
		xv_in[3] = in_data.x_sample_1;
		xv_in[4] = in_data.x_sample_0;
		yv_in[0] = in_data.y_sample_4;
		yv_in[1] = in_data.y_sample_3;
		yv_in[2] = in_data.y_sample_2;
		yv_in[3] = in_data.y_sample_1;
		yv_in[4] = in_data.y_sample_0;
		for (int i = 0; i < N_SAMPLES - 1; i++) begin
			for (int j = i + 1; j < N_SAMPLES; j++) begin
				xd_in[pair_idx(i, j)] = absd(xv_in[i], xv_in[j]);
				yd_in[pair_idx(i, j)] = absd(yv_in[i], yv_in[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xv_s1   <= xv_in;
			yv_s1   <= yv_in;
			xd_s1   <= xd_in;
			yd_s1   <= yd_in;
			pen_s1  <= in_data.pen_levels;
			xv_s2   <= xv_s1;
			yv_s2   <= yv_s1;
			xd_s2   <= xd_s1;
			yd_s2   <= yd_s1;
			pen_s2  <= pen_s1;
			dmax_s2 <= maxd(max_tree(xd_s1), max_tree(yd_s1));
		end
	end

	always_comb begin
		push_data.xv   = xv_s2;
		push_data.yv   = yv_s2;
		push_data.xd   = xd_s2;
		push_data.yd   = yd_s2;
		push_data.pen  = pen_s2;
		push_data.dmax = dmax_s2;
	end

endmodule

/* src/tsfc_queue.sv */
// Short FIFO that decouples the front end from the back end.
// Depends on tsfc_pkg for the entry type.
module tsfc_queue
	import tsfc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  fe_entry_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      valid,
	output fe_entry_t data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	fe_entry_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign data    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* src/tsfc_back.sv */
// Back end: stylus checks, triple search, range adaptation and calibration.
// Depends on tsfc_pkg; reads entries from tsfc_queue.
module tsfc_back
	import tsfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  fe_entry_t q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam logic [1:0] CHK_NONE   = 2'd0;
	localparam logic [1:0] CHK_PEN    = 2'd1;
	localparam logic [1:0] CHK_BOUNCE = 2'd2;

	localparam logic signed [SAMPLE_W:0] X_MAX = (SAMPLE_W + 1)'(SCREEN_WIDTH - 1);
	localparam logic signed [SAMPLE_W:0] Y_MAX = (SAMPLE_W + 1)'(SCREEN_HEIGHT - 1);

	typedef struct packed {
		logic       bad;
		logic [2:0] i;
		logic [2:0] j;
		logic [2:0] k;
	} sel_t;

	function automatic logic [1:0] stylus(input logic touched, input logic first,
		input logic second);
		logic [1:0] r;
		if (first) begin
			r = CHK_PEN;
		end else if (touched && second) begin
			r = CHK_BOUNCE;
		end else begin
			r = CHK_NONE;
		end
		return r;
	endfunction

	// Last agreeing pair (i, j) wins, with the first agreeing k after j.
	function automatic sel_t select_triple(input diffs_t d, input logic [RANGE_W-1:0] rng);
		sel_t                s;
		logic                found;
		logic [2:0]          kk;
		logic [SAMPLE_W-1:0] lim;
		lim = {{(SAMPLE_W - RANGE_W){1'b0}}, rng};
		s   = '{bad: 1'b1, i: 3'd0, j: 3'd0, k: 3'd0};
		for (int i = 0; i < 3; i++) begin
			for (int j = i + 1; j < 4; j++) begin
				found = 1'b0;
				kk    = 3'd0;
				for (int k = j + 1; k < N_SAMPLES; k++) begin
					if (!found && d[pair_idx(i, k)] <= lim) begin
						found = 1'b1;
						kk    = 3'(k);
					end
				end
				if (found && d[pair_idx(i, j)] <= lim) begin
					s = '{bad: 1'b0, i: 3'(i), j: 3'(j), k: kk};
				end
			end
		end
		return s;
	endfunction

	function automatic logic [SAMPLE_W-1:0] axis_value(input samples_t v, input sel_t s);
		logic [SAMPLE_W+1:0] acc;
		logic [SAMPLE_W-1:0] val;
		if (s.bad) begin
			acc = {2'b00, v[0]} + {2'b00, v[4]};
			val = acc[SAMPLE_W:1];
		end else begin
			acc = {2'b00, v[s.j]} + {1'b0, v[s.i], 1'b0} + {2'b00, v[s.k]};
			val = acc[SAMPLE_W+1:2];
		end
		return {val[SAMPLE_W-1:3], 3'b000};
	endfunction

	// scale/2 truncated toward zero, minus the offset, modulo 2^32.
	function automatic logic [CAL_W-1:0] cal_adjust(input logic [CAL_W-1:0] scale,
		input logic [CAL_W-1:0] offset);
		logic [CAL_W-1:0] tmp;
		logic [CAL_W-1:0] half;
		tmp  = scale + {{(CAL_W - 1){1'b0}}, scale[CAL_W-1]};
		half = {tmp[CAL_W-1], tmp[CAL_W-1:1]};
		return half - offset;
	endfunction

	function automatic logic [PIX_W-1:0] cal_clamp(input logic [CAL_W-1:0] prod,
		input logic [CAL_W-1:0] adj, input logic signed [SAMPLE_W:0] lim);
		logic [CAL_W-1:0]           sum;
		logic signed [SAMPLE_W:0]   p;
		sum = prod + adj;
		p   = $signed(sum[CAL_W-1:CAL_SHIFT]);
		if (p < 0) begin
			p = '0;
		end else if (p > lim) begin
			p = lim;
		end
		return p[PIX_W-1:0];
	endfunction

	logic en;
	logic valid_b1, valid_b2, valid_b3, valid_b4;

	// Adaptive filter state.
	logic [RANGE_W-1:0] agree_range_q;
	logic [2:0]         tight_count_q, fail_count_q;
	logic               was_touched_q;
	logic [PIX_W-1:0]   last_screen_x_q, last_screen_y_q;

	logic [1:0]          first_chk, second_chk;
	sel_t                xsel, ysel;
	logic                sampled_c, touched_c;
	logic [ERR_W-1:0]    err_c;
	logic [SAMPLE_W-1:0] dmax_c;
	logic [RANGE_W-1:0]  range_n;
	logic [2:0]          tight_n, fail_n;

	samples_t            xv_b1, yv_b1;
	sel_t                xsel_b1, ysel_b1;
	logic                sampled_b1, sampled_b2, sampled_b3, sampled_b4;
	logic [ERR_W-1:0]    err_b1, err_b2, err_b3, err_b4;
	logic [SAMPLE_W-1:0] dmax_b1, dmax_b2, dmax_b3, dmax_b4;
	logic [SAMPLE_W-1:0] fx_b2, fy_b2, fx_b3, fy_b3, fx_b4, fy_b4;
	logic [CAL_W-1:0]    prodx_b3, prody_b3, adjx_b3, adjy_b3;

	assign en        = !valid_b4 || out_ready;
	assign q_pop     = q_valid && en;
	assign out_valid = valid_b4;

	always_comb begin
		first_chk  = stylus(was_touched_q, q_data.pen[0], q_data.pen[1]);
		second_chk = stylus(was_touched_q, q_data.pen[2], q_data.pen[3]);
		xsel       = select_triple(q_data.xd, agree_range_q);
		ysel       = select_triple(q_data.yd, agree_range_q);

		if (first_chk == CHK_NONE) begin
			sampled_c = 1'b0;
			touched_c = 1'b0;
			err_c     = ERR_ALL;
			dmax_c    = '0;
		end else begin
			sampled_c = 1'b1;
			dmax_c    = q_data.dmax;
			touched_c = (second_chk == CHK_PEN);
			if (first_chk == CHK_BOUNCE || second_chk == CHK_BOUNCE) begin
				err_c = ERR_ALL;
			end else begin
				err_c = {ysel.bad, xsel.bad};
			end
		end

		range_n = agree_range_q;
		tight_n = tight_count_q;
		fail_n  = fail_count_q;
		if (!touched_c) begin
			tight_n = '0;
			fail_n  = '0;
		end else if (err_c == '0) begin
			fail_n = '0;
			if (dmax_c >= {{(SAMPLE_W - RANGE_W + 1){1'b0}}, agree_range_q[RANGE_W-1:1]}) begin
				tight_n = '0;
			end else if (tight_count_q >= 3'd3) begin
				// Fourth steady frame in a row: tighten the range.
				tight_n = '0;
				if (agree_range_q > cfg.min_range) begin
					range_n = agree_range_q - 1'b1;
					fail_n  = 3'd3;
				end
			end else begin
				tight_n = tight_count_q + 1'b1;
			end
		end else begin
			tight_n = '0;
			if (fail_count_q >= 3'd3) begin
				// Fourth failing frame: widen the range.
				fail_n = '0;
				if (agree_range_q < RANGE_CEILING) begin
					range_n = agree_range_q + 1'b1;
				end
			end else begin
				fail_n = fail_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1        <= 1'b0;
			valid_b2        <= 1'b0;
			valid_b3        <= 1'b0;
			valid_b4        <= 1'b0;
			agree_range_q   <= RANGE_RESET;
			tight_count_q   <= '0;
			fail_count_q    <= '0;
			was_touched_q   <= 1'b0;
			last_screen_x_q <= '0;
			last_screen_y_q <= '0;
		end else if (en) begin
			valid_b1 <= q_valid;
			valid_b2 <= valid_b1;
			valid_b3 <= valid_b2;
			valid_b4 <= valid_b3;
			if (q_valid) begin
				agree_range_q <= range_n;
				tight_count_q <= tight_n;
				fail_count_q  <= fail_n;
				was_touched_q <= touched_c;
			end
			if (valid_b3 && sampled_b3) begin
				last_screen_x_q <= cal_clamp(prodx_b3, adjx_b3, X_MAX);
				last_screen_y_q <= cal_clamp(prody_b3, adjy_b3, Y_MAX);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xv_b1      <= q_data.xv;
			yv_b1      <= q_data.yv;
			xsel_b1    <= xsel;
			ysel_b1    <= ysel;
			sampled_b1 <= sampled_c;
			err_b1     <= err_c;
			dmax_b1    <= dmax_c;

			fx_b2      <= sampled_b1 ? axis_value(xv_b1, xsel_b1) : '0;
			fy_b2      <= sampled_b1 ? axis_value(yv_b1, ysel_b1) : '0;
			sampled_b2 <= sampled_b1;
			err_b2     <= err_b1;
			dmax_b2    <= dmax_b1;

			prodx_b3   <= CAL_W'({{(CAL_W - SAMPLE_W){1'b0}}, fx_b2} * cfg.x_scale);
			prody_b3   <= CAL_W'({{(CAL_W - SAMPLE_W){1'b0}}, fy_b2} * cfg.y_scale);
			adjx_b3    <= cal_adjust(cfg.x_scale, cfg.x_offset);
			adjy_b3    <= cal_adjust(cfg.y_scale, cfg.y_offset);
			fx_b3      <= fx_b2;
			fy_b3      <= fy_b2;
			sampled_b3 <= sampled_b2;
			err_b3     <= err_b2;
			dmax_b3    <= dmax_b2;

			fx_b4      <= fx_b3;
			fy_b4      <= fy_b3;
			sampled_b4 <= sampled_b3;
			err_b4     <= err_b3;
			dmax_b4    <= dmax_b3;
		end
	end

	always_comb begin
		out_data.filtered_x     = fx_b4;
		out_data.filtered_y     = fy_b4;
		out_data.screen_x       = last_screen_x_q;
		out_data.screen_y       = last_screen_y_q;
		out_data.error_location = err_b4;
		out_data.max_deviation  = dmax_b4;
		out_data.sampled        = sampled_b4;
	end

	a_range_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		agree_range_q <= RANGE_CEILING)
		else $error("agree range above its ceiling");

	a_tight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tight_count_q <= 3'd3)
		else $error("tight counter past its wrap point");

	a_fail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fail_count_q <= 3'd3)
		else $error("fail counter past its wrap point");

	a_state_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!q_pop |=> $stable(agree_range_q) && $stable(was_touched_q))
		else $error("filter state changed without a frame leaving the queue");

endmodule

/* src/touch_sample_filter_calibrate_core.sv */
// Throughput: one frame per cycle while the result channel is not stalled; the adaptive
// range update in the first back-end stage is combinational and is registered as each
// frame is popped, so it never holds off the next frame.
// Reset clears all handshake and filter state at once (range 20, counters and pen
// history zero, last pixels zero) and loads the register defaults; no clearing pass.
module touch_sample_filter_calibrate_core
	import tsfc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tsfc_chan_if.sink            frame,
	tsfc_chan_if.source          result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_wdata
);

	// The front end reorders the samples into filter order and computes every
	// pairwise spread and the frame's largest spread. None of that depends on
	// the adaptive state, so it runs ahead of the back end and parks finished
	// frames in the queue.
	//
	// The back end pops one frame per cycle while the queue holds a frame and the
	// output is not stalled. Its first stage runs both stylus checks against the
	// pen history, searches the agreeing triple on each axis with the current range
	// and updates range, counters and pen history in the same cycle, so the next
	// frame sees the new state. Later stages form the filtered values, multiply by
	// the gains, then shift, clamp and hold the last pixels in the output register.

	cfg_t      cfg_q;
	logic      q_full, q_push, q_pop, q_valid;
	fe_entry_t q_push_data, q_data;
	in_beat_t  frame_data;
	out_beat_t result_data;

	assign frame_data  = frame.data;
	assign result.data = result_data;

	// Register writes must only be issued while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_scale   <= SCALE_RESET;
			cfg_q.x_offset  <= '0;
			cfg_q.y_scale   <= SCALE_RESET;
			cfg_q.y_offset  <= '0;
			cfg_q.min_range <= RANGE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_X_SCALE: begin
					cfg_q.x_scale <= cfg_wdata;
				end
				REG_X_OFFSET: begin
					cfg_q.x_offset <= cfg_wdata;
				end
				REG_Y_SCALE: begin
					cfg_q.y_scale <= cfg_wdata;
				end
				REG_Y_OFFSET: begin
					cfg_q.y_offset <= cfg_wdata;
				end
				REG_MIN_RANGE: begin
					cfg_q.min_range <= cfg_wdata[RANGE_W-1:0];
				end
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	tsfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (frame.valid),
		.in_ready  (frame.ready),
		.in_data   (frame_data),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	tsfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	tsfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result_data)
	);

endmodule
